// ----- hdl/spk_pkg.sv -----
// Shared constants, types and helpers for the SPH pair kernel gradient unit.
// No dependencies.
`default_nettype none

package spk_pkg;

    localparam int SPK_FRAC_BITS = 16;
    localparam logic [31:0] INV_PI_Q32 = 32'd1367130551;

    localparam int POS_W  = 32;
    localparam int SLEN_W = 31;
    localparam int WT_W   = 31;
    localparam int GRAD_W = 32;
    localparam int DIFF_W = 33;
    localparam int ABS_W  = 33;
    localparam int D2_W   = 66;
    localparam int ROOT_W = 34;
    localparam int TRIAL_W = 70;
    localparam int H2_W   = 62;
    localparam int H3_W   = 93;
    localparam int H4_W   = 124;
    localparam int QUO_W  = 33;

    localparam logic [WT_W-1:0] WT_MAX = {WT_W{1'b1}};

    typedef struct packed {
        logic [2:0][ABS_W-1:0] a;
        logic [2:0]            neg;
        logic [2:0]            nz;
        logic                  hz;
        logic [SLEN_W-1:0]     h;
        logic [H3_W-1:0]       h3;
        logic [H4_W-1:0]       h4;
    } sqside_t;

    function automatic logic [GRAD_W-1:0] clamp_grad(
        input logic             neg,
        input logic             nz,
        input logic [QUO_W-1:0] mag
    );
        logic [QUO_W-1:0]  m;
        logic [GRAD_W-1:0] res;
        m = mag;
        res = '0;
        if (nz && !neg)
        begin
            if (m > QUO_W'(33'h0_8000_0000))
            begin
                m = QUO_W'(33'h0_8000_0000);
            end
            res = GRAD_W'(QUO_W'(0) - m);
        end
        else if (nz)
        begin
            if (m > QUO_W'(33'h0_7FFF_FFFF))
            begin
                m = QUO_W'(33'h0_7FFF_FFFF);
            end
            res = m[GRAD_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/sph_pair_kernel_gradient_unit.sv -----
// Top level of the SPH pair kernel gradient unit: cubic spline weight and gradient per pair.
// Depends on spk_pkg and spk_div.
`default_nettype none

// Takes one particle pair per clock while not stalled and returns the 3D cubic spline
// kernel weight (unsigned) and gradient (signed) in fixed point with FRAC_BITS fraction
// bits. The pipeline is fully streaming: a new pair may enter on every cycle unless the
// result side stalls, and results leave in order, one per pair. It is made of three front
// stages, the root entry register and its 34 stages, the distance divider (FRAC_BITS + 3
// stages), five polynomial and multiply stages, the 34-stage weight and gradient dividers,
// and the output register.
// A stall on the result side holds the whole pipeline; nothing is dropped or repeated.
// Pairs that are coincident, out of support, or whose weight truncates to zero come back
// with is_neighbor low and every other field zero.

module sph_pair_kernel_gradient_unit
    import spk_pkg::*;
#(
    parameter int FRAC_BITS = SPK_FRAC_BITS
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     pair_valid,
    output logic                     pair_ready,
    input  logic signed [POS_W-1:0]  pos_i_x,
    input  logic signed [POS_W-1:0]  pos_i_y,
    input  logic signed [POS_W-1:0]  pos_i_z,
    input  logic signed [POS_W-1:0]  pos_j_x,
    input  logic signed [POS_W-1:0]  pos_j_y,
    input  logic signed [POS_W-1:0]  pos_j_z,
    input  logic [SLEN_W-1:0]        smooth_len_i,
    input  logic [SLEN_W-1:0]        smooth_len_j,
    output logic                     res_valid,
    input  logic                     res_ready,
    output logic                     is_neighbor,
    output logic [WT_W-1:0]          weight,
    output logic signed [GRAD_W-1:0] grad_x,
    output logic signed [GRAD_W-1:0] grad_y,
    output logic signed [GRAD_W-1:0] grad_z
);

    localparam int F     = FRAC_BITS;
    localparam int QW    = F + 2;
    localparam int GM_W  = F + 2;
    localparam int IP_W  = F - 1;
    localparam int FI_W  = 2 * F;
    localparam int GI_W  = 2 * F + 1;
    localparam int UGI_W = 3 * F + 2;
    localparam int TAGQ_W = 2 + H3_W + H4_W;

    localparam logic [32:0] IP_RND = 33'(INV_PI_Q32) + (33'd1 << (31 - F));
    localparam logic [IP_W-1:0] IP = IP_W'(IP_RND >> (32 - F));
    localparam logic [QW-1:0] ONE_Q = QW'(1) << F;
    localparam logic [QW-1:0] TWO_Q = QW'(1) << (F + 1);

    typedef struct packed {
        logic              kill;
        logic [H3_W-1:0]   h3;
        logic [H4_W-1:0]   h4;
        logic [2:0][F:0]   u;
        logic [2:0]        neg;
        logic [2:0]        nz;
    } pside_t;

    logic en;

    // front stages
    logic                     p1_v_reg, p2_v_reg, p3_v_reg;
    logic [2:0][DIFF_W-1:0]   p1_r_reg;
    logic [SLEN_W-1:0]        p1_h_reg;
    logic [2:0][ABS_W-1:0]    p2_a_reg, p3_a_reg;
    logic [2:0]               p2_neg_reg, p2_nz_reg, p3_neg_reg, p3_nz_reg;
    logic [SLEN_W-1:0]        p2_h_reg, p3_h_reg;
    logic                     p2_hz_reg, p3_hz_reg;
    logic [H2_W-1:0]          p2_h2_reg;
    logic [2:0][D2_W-1:0]     p3_sq_reg;
    logic [62:0]              p3_h3lo_reg;
    logic [60:0]              p3_h3hi_reg;
    logic [63:0]              p3_h4ll_reg;
    logic [61:0]              p3_h4lh_reg;
    logic [59:0]              p3_h4hh_reg;

    // square root
    logic                     sq_v_reg    [ROOT_W+1];
    logic [D2_W-1:0]          sq_rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0]        sq_root_reg [ROOT_W+1];
    sqside_t                  sq_side_reg [ROOT_W+1];
    sqside_t                  sq_side_next;

    // distance and direction dividers
    logic [QW-1:0]            qd_quo;
    logic [TAGQ_W-1:0]        qd_tag;
    logic [2:0][QW-1:0]       ud_quo;
    logic [2:0][1:0]          ud_tag;
    logic                     sq_kill;

    // polynomial stages
    logic                     pv_reg [5];
    pside_t                   ps_reg [5];
    pside_t                   ps_next;
    logic                     pa_lt_next;
    logic [QW-1:0]            pa_t;
    logic [F:0]               pa_x_next;
    logic [2*F+1:0]           pa_sq;
    logic                     pa_lt_reg, pb_lt_reg;
    logic [F:0]               pa_x_reg, pa_x2_reg, pb_x_reg, pb_x2_reg, pb_x3_reg;
    logic [2*F+1:0]           pb_cube;
    logic [F+2:0]             pc_pos, pc_neg1, pc_gm3;
    logic [F+3:0]             pc_tq, pc_neg2;
    logic [F:0]               pc_f_next, pc_f_reg;
    logic [GM_W-1:0]          pc_gm_next, pc_gm_reg;
    logic [FI_W-1:0]          pd_fi_reg, pe_fi_reg;
    logic [GI_W-1:0]          pd_gi_reg;
    logic [2:0][UGI_W-1:0]    pe_ugi_reg;

    // weight and gradient dividers
    logic [QUO_W-1:0]         wd_quo;
    logic [1:0]               wd_tag;
    logic [2:0][QUO_W-1:0]    md_quo;
    logic [2:0][1:0]          md_tag;

    // output
    logic                     fin_nb;
    logic [WT_W-1:0]          fin_wt;
    logic                     res_valid_reg, nb_reg;
    logic [WT_W-1:0]          wt_reg;
    logic [2:0][GRAD_W-1:0]   grad_reg;

    assign en         = !res_valid_reg || res_ready;
    assign pair_ready = en;

    // valid chain of the front and polynomial stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            for (int i = 0; i < 5; i++)
            begin
                pv_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            p1_v_reg  <= pair_valid;
            p2_v_reg  <= p1_v_reg;
            p3_v_reg  <= p2_v_reg;
            pv_reg[0] <= qd_tag[TAGQ_W-1];
            for (int i = 1; i < 5; i++)
            begin
                pv_reg[i] <= pv_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_r_reg[0] <= {pos_i_x[POS_W-1], pos_i_x} - {pos_j_x[POS_W-1], pos_j_x};
            p1_r_reg[1] <= {pos_i_y[POS_W-1], pos_i_y} - {pos_j_y[POS_W-1], pos_j_y};
            p1_r_reg[2] <= {pos_i_z[POS_W-1], pos_i_z} - {pos_j_z[POS_W-1], pos_j_z};
            p1_h_reg    <= SLEN_W'(({1'b0, smooth_len_i} + {1'b0, smooth_len_j}) >> 1);

            for (int c = 0; c < 3; c++)
            begin
                p2_a_reg[c]   <= p1_r_reg[c][DIFF_W-1] ? DIFF_W'(0) - p1_r_reg[c]
                                                        : p1_r_reg[c];
                p2_neg_reg[c] <= p1_r_reg[c][DIFF_W-1];
                p2_nz_reg[c]  <= |p1_r_reg[c];
            end
            p2_h_reg  <= p1_h_reg;
            p2_hz_reg <= p1_h_reg == '0;
            p2_h2_reg <= H2_W'(p1_h_reg) * H2_W'(p1_h_reg);

            for (int c = 0; c < 3; c++)
            begin
                p3_sq_reg[c] <= D2_W'(p2_a_reg[c]) * D2_W'(p2_a_reg[c]);
            end
            p3_a_reg    <= p2_a_reg;
            p3_neg_reg  <= p2_neg_reg;
            p3_nz_reg   <= p2_nz_reg;
            p3_h_reg    <= p2_h_reg;
            p3_hz_reg   <= p2_hz_reg;
            p3_h3lo_reg <= 63'(p2_h2_reg[31:0]) * 63'(p2_h_reg);
            p3_h3hi_reg <= 61'(p2_h2_reg[61:32]) * 61'(p2_h_reg);
            p3_h4ll_reg <= 64'(p2_h2_reg[31:0]) * 64'(p2_h2_reg[31:0]);
            p3_h4lh_reg <= 62'(p2_h2_reg[31:0]) * 62'(p2_h2_reg[61:32]);
            p3_h4hh_reg <= 60'(p2_h2_reg[61:32]) * 60'(p2_h2_reg[61:32]);
        end
    end

    // sum of squares and powers of h enter the root pipeline
    always_comb
    begin
        sq_side_next.a   = p3_a_reg;
        sq_side_next.neg = p3_neg_reg;
        sq_side_next.nz  = p3_nz_reg;
        sq_side_next.hz  = p3_hz_reg;
        sq_side_next.h   = p3_h_reg;
        sq_side_next.h3  = H3_W'(p3_h3lo_reg) + (H3_W'(p3_h3hi_reg) << 32);
        sq_side_next.h4  = H4_W'(p3_h4ll_reg) + (H4_W'(p3_h4lh_reg) << 33)
                         + (H4_W'(p3_h4hh_reg) << 64);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sq_v_reg[0] <= p3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_rem_reg[0]  <= p3_sq_reg[0] + p3_sq_reg[1] + p3_sq_reg[2];
            sq_root_reg[0] <= '0;
            sq_side_reg[0] <= sq_side_next;
        end
    end

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_root
        localparam int B = ROOT_W - 1 - k;
        logic [TRIAL_W-1:0] trial;
        logic               ge;

        always_comb
        begin
            trial = (TRIAL_W'(sq_root_reg[k]) << (B + 1)) | (TRIAL_W'(1) << (2 * B));
            ge    = TRIAL_W'(sq_rem_reg[k]) >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                sq_v_reg[k+1] <= sq_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_rem_reg[k+1]  <= ge ? sq_rem_reg[k] - D2_W'(trial) : sq_rem_reg[k];
                sq_root_reg[k+1] <= sq_root_reg[k] | (ROOT_W'(ge) << B);
                sq_side_reg[k+1] <= sq_side_reg[k];
            end
        end
    end

    assign sq_kill = sq_side_reg[ROOT_W].hz || (sq_root_reg[ROOT_W] == '0);

    spk_div #(
        .NW (ROOT_W + F),
        .DW (SLEN_W),
        .QW (QW),
        .TW (TAGQ_W)
    ) u_qdiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .num     ({sq_root_reg[ROOT_W], F'(0)}),
        .den     (sq_side_reg[ROOT_W].h),
        .tag_in  ({sq_v_reg[ROOT_W], sq_kill, sq_side_reg[ROOT_W].h3,
                   sq_side_reg[ROOT_W].h4}),
        .quo     (qd_quo),
        .tag_out (qd_tag)
    );

    for (genvar c = 0; c < 3; c++)
    begin : g_udiv
        spk_div #(
            .NW (ABS_W + F),
            .DW (ROOT_W),
            .QW (QW),
            .TW (2)
        ) u_udiv (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .num     ({sq_side_reg[ROOT_W].a[c], F'(0)}),
            .den     (sq_root_reg[ROOT_W]),
            .tag_in  ({sq_side_reg[ROOT_W].neg[c], sq_side_reg[ROOT_W].nz[c]}),
            .quo     (ud_quo[c]),
            .tag_out (ud_tag[c])
        );
    end

    // q < 1 uses q itself, 1 <= q <= 2 uses 2 - q
    always_comb
    begin
        ps_next.kill = qd_tag[TAGQ_W-2] || (qd_quo > TWO_Q);
        ps_next.h3   = qd_tag[H3_W+H4_W-1:H4_W];
        ps_next.h4   = qd_tag[H4_W-1:0];
        for (int c = 0; c < 3; c++)
        begin
            ps_next.u[c]   = ud_quo[c][F:0];
            ps_next.neg[c] = ud_tag[c][1];
            ps_next.nz[c]  = ud_tag[c][0];
        end
        pa_lt_next = qd_quo < ONE_Q;
        pa_t       = TWO_Q - qd_quo;
        pa_x_next  = pa_lt_next ? qd_quo[F:0] : pa_t[F:0];
        pa_sq      = (2*F+2)'(pa_x_next) * (2*F+2)'(pa_x_next);
    end

    always_comb
    begin
        pb_cube = (2*F+2)'(pa_x2_reg) * (2*F+2)'(pa_x_reg);
    end

    always_comb
    begin
        pc_pos  = (F+3)'(ONE_Q) + (((F+3)'(pb_x3_reg) * (F+3)'(3)) >> 2);
        pc_neg1 = ((F+3)'(pb_x2_reg) * (F+3)'(3)) >> 1;
        pc_gm3  = ((F+3)'(pb_x2_reg) * (F+3)'(3)) >> 2;
        pc_tq   = (F+4)'(pb_x_reg) * (F+4)'(3);
        pc_neg2 = ((F+4)'(pb_x2_reg) * (F+4)'(9)) >> 2;
        if (pb_lt_reg)
        begin
            pc_f_next  = (pc_pos > pc_neg1) ? (F+1)'(pc_pos - pc_neg1) : '0;
            pc_gm_next = (pc_tq > pc_neg2) ? GM_W'(pc_tq - pc_neg2) : '0;
        end
        else
        begin
            pc_f_next  = pb_x3_reg >> 2;
            pc_gm_next = GM_W'(pc_gm3);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ps_reg[0] <= ps_next;
            for (int i = 1; i < 5; i++)
            begin
                ps_reg[i] <= ps_reg[i-1];
            end

            pa_lt_reg <= pa_lt_next;
            pa_x_reg  <= pa_x_next;
            pa_x2_reg <= (F+1)'(pa_sq >> F);

            pb_lt_reg <= pa_lt_reg;
            pb_x_reg  <= pa_x_reg;
            pb_x2_reg <= pa_x2_reg;
            pb_x3_reg <= (F+1)'(pb_cube >> F);

            pc_f_reg  <= pc_f_next;
            pc_gm_reg <= pc_gm_next;

            pd_fi_reg <= FI_W'(pc_f_reg) * FI_W'(IP);
            pd_gi_reg <= GI_W'(pc_gm_reg) * GI_W'(IP);

            pe_fi_reg <= pd_fi_reg;
            for (int c = 0; c < 3; c++)
            begin
                pe_ugi_reg[c] <= UGI_W'(ps_reg[3].u[c]) * UGI_W'(pd_gi_reg);
            end
        end
    end

    spk_div #(
        .NW (4 * F),
        .DW (H3_W),
        .QW (QUO_W),
        .TW (2)
    ) u_wdiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .num     ({pe_fi_reg, (2*F)'(0)}),
        .den     (ps_reg[4].h3),
        .tag_in  ({pv_reg[4], ps_reg[4].kill}),
        .quo     (wd_quo),
        .tag_out (wd_tag)
    );

    for (genvar c = 0; c < 3; c++)
    begin : g_mdiv
        spk_div #(
            .NW (5 * F + 2),
            .DW (H4_W),
            .QW (QUO_W),
            .TW (2)
        ) u_mdiv (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .num     ({pe_ugi_reg[c], (2*F)'(0)}),
            .den     (ps_reg[4].h4),
            .tag_in  ({ps_reg[4].neg[c], ps_reg[4].nz[c]}),
            .quo     (md_quo[c]),
            .tag_out (md_tag[c])
        );
    end

    always_comb
    begin
        fin_nb = !wd_tag[0] && (wd_quo != '0);
        fin_wt = (wd_quo > QUO_W'(WT_MAX)) ? WT_MAX : wd_quo[WT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            res_valid_reg <= wd_tag[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nb_reg <= fin_nb;
            wt_reg <= fin_nb ? fin_wt : '0;
            for (int c = 0; c < 3; c++)
            begin
                grad_reg[c] <= fin_nb ? clamp_grad(md_tag[c][1], md_tag[c][0], md_quo[c])
                                      : '0;
            end
        end
    end

    assign res_valid   = res_valid_reg;
    assign is_neighbor = nb_reg;
    assign weight      = wt_reg;
    assign grad_x      = grad_reg[0];
    assign grad_y      = grad_reg[1];
    assign grad_z      = grad_reg[2];

endmodule

`default_nettype wire

// ----- hdl/spk_div.sv -----
// Pipelined restoring divider with saturation and a tag that travels with each word.
// One quotient bit per stage, after an input register. No dependencies.
`default_nettype none

module spk_div #(
    parameter int NW = 8,
    parameter int DW = 8,
    parameter int QW = 4,
    parameter int TW = 1
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [TW-1:0] tag_in,
    output logic [QW-1:0] quo,
    output logic [TW-1:0] tag_out
);

    localparam int MW = (NW > DW) ? NW : DW;

    logic [NW-1:0] rem_reg [QW+1];
    logic [DW-1:0] den_reg [QW+1];
    logic [QW-1:0] quo_reg [QW+1];
    logic          sat_reg [QW+1];
    logic [TW-1:0] tag_reg [QW+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            quo_reg[0] <= '0;
            sat_reg[0] <= MW'(num >> QW) >= MW'(den);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[0] <= '0;
        end
        else if (en)
        begin
            tag_reg[0] <= tag_in;
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        localparam int B = QW - 1 - k;
        logic [MW-1:0] part;
        logic          ge;

        always_comb
        begin
            part = MW'(rem_reg[k] >> B);
            ge   = part >= MW'(den_reg[k]);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= ge ? rem_reg[k] - NW'((NW+DW)'(den_reg[k]) << B)
                                   : rem_reg[k];
                den_reg[k+1] <= den_reg[k];
                quo_reg[k+1] <= quo_reg[k] | (QW'(ge) << B);
                sat_reg[k+1] <= sat_reg[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[k+1] <= '0;
            end
            else if (en)
            begin
                tag_reg[k+1] <= tag_reg[k];
            end
        end
    end

    assign quo     = sat_reg[QW] ? {QW{1'b1}} : quo_reg[QW];
    assign tag_out = tag_reg[QW];

endmodule

`default_nettype wire

// ----- hdl/spk_check.sv -----
// Port-level checker for the SPH pair kernel gradient unit, bound to the top level.
// Depends on spk_pkg and sph_pair_kernel_gradient_unit.
`default_nettype none

module spk_check
    import spk_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              pair_ready,
    input logic              res_valid,
    input logic              res_ready,
    input logic              is_neighbor,
    input logic [WT_W-1:0]   weight,
    input logic [GRAD_W-1:0] grad_x,
    input logic [GRAD_W-1:0] grad_y,
    input logic [GRAD_W-1:0] grad_z
);

    a_non_neighbor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !is_neighbor |->
            weight == '0 && grad_x == '0 && grad_y == '0 && grad_z == '0)
        else $error("non-neighbor word carries nonzero fields");

    a_neighbor_weight: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && is_neighbor |-> weight != '0)
        else $error("neighbor word with zero weight");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> pair_ready)
        else $error("input stalled with empty output");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=>
            res_valid && $stable(is_neighbor) && $stable(weight)
            && $stable(grad_x) && $stable(grad_y) && $stable(grad_z))
        else $error("stalled result word changed");

endmodule

bind sph_pair_kernel_gradient_unit spk_check u_spk_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .pair_ready  (pair_ready),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .is_neighbor (is_neighbor),
    .weight      (weight),
    .grad_x      (grad_x),
    .grad_y      (grad_y),
    .grad_z      (grad_z)
);

`default_nettype wire

// ----- bench/tb.sv -----
// Testbench for sph_pair_kernel_gradient_unit: drives particle pairs, predicts the
// cubic spline kernel weight and gradient per pair in plain SystemVerilog arithmetic
// and checks every result word in order. Depends on spk_pkg and the unit RTL.
`timescale 1ns / 100ps

module tb;
    import spk_pkg::*;

    localparam int FB = SPK_FRAC_BITS;
    localparam int LATENCY = FB + 81;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [POS_W-1:0]  pix, piy, piz, pjx, pjy, pjz;
        logic [SLEN_W-1:0] hi, hj;
    } pair_t;

    typedef struct packed {
        logic              nb;
        logic [WT_W-1:0]   w;
        logic [GRAD_W-1:0] gx, gy, gz;
    } kernel_t;

    logic clk, rst_n;
    logic pair_valid, pair_ready, res_valid, res_ready;
    logic signed [POS_W-1:0] pos_i_x, pos_i_y, pos_i_z, pos_j_x, pos_j_y, pos_j_z;
    logic [SLEN_W-1:0] smooth_len_i, smooth_len_j;
    logic is_neighbor;
    logic [WT_W-1:0] weight;
    logic signed [GRAD_W-1:0] grad_x, grad_y, grad_z;

    kernel_t expected_kernels[$];
    int mismatches;
    int idle_cycles;
    bit hold_off;
    bit quiet_sink;

    sph_pair_kernel_gradient_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .pair_valid(pair_valid), .pair_ready(pair_ready),
        .pos_i_x(pos_i_x), .pos_i_y(pos_i_y), .pos_i_z(pos_i_z),
        .pos_j_x(pos_j_x), .pos_j_y(pos_j_y), .pos_j_z(pos_j_z),
        .smooth_len_i(smooth_len_i), .smooth_len_j(smooth_len_j),
        .res_valid(res_valid), .res_ready(res_ready),
        .is_neighbor(is_neighbor), .weight(weight),
        .grad_x(grad_x), .grad_y(grad_y), .grad_z(grad_z)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [33:0] floor_div(logic [255:0] n, logic [255:0] d);
        logic [255:0] qt;
        qt = n / d;
        if (qt > 256'h1_FFFF_FFFF)
            qt = 256'h1_FFFF_FFFF;
        return qt[33:0];
    endfunction

    function automatic logic [GRAD_W-1:0] signed_grad(logic signed [33:0] r,
                                                      logic [33:0] mag);
        if (r > 0)
        begin
            if (mag > 34'h0_8000_0000)
                mag = 34'h0_8000_0000;
            return GRAD_W'(34'd0 - mag);
        end
        if (r < 0)
        begin
            if (mag > 34'h0_7FFF_FFFF)
                mag = 34'h0_7FFF_FFFF;
            return mag[GRAD_W-1:0];
        end
        return '0;
    endfunction

    function automatic kernel_t predict_kernel(pair_t p);
        kernel_t k;
        logic signed [33:0] r[3];
        logic [33:0] a[3];
        logic [67:0] d2;
        logic [33:0] d, cand, mag;
        logic [63:0] h, q, f, gm, one, ip, q2, q3, pos, neg, t, t2, t3, u;
        logic [255:0] h3, h4, num;
        logic [33:0] w;
        k = '0;
        one = 64'd1 << FB;
        ip = (64'(INV_PI_Q32) + (64'd1 << (31 - FB))) >> (32 - FB);
        h = (64'(p.hi) + 64'(p.hj)) >> 1;
        r[0] = 34'(signed'(p.pix)) - 34'(signed'(p.pjx));
        r[1] = 34'(signed'(p.piy)) - 34'(signed'(p.pjy));
        r[2] = 34'(signed'(p.piz)) - 34'(signed'(p.pjz));
        d2 = '0;
        for (int c = 0; c < 3; c++)
        begin
            a[c] = r[c] < 0 ? -r[c] : r[c];
            d2 += 68'(a[c]) * 68'(a[c]);
        end
        if (h == 0 || d2 == 0)
            return k;
        d = '0;
        for (int b = 33; b >= 0; b--)
        begin
            cand = d | (34'd1 << b);
            if (d2 >= 68'(cand) * 68'(cand))
                d = cand;
        end
        q = (64'(d) << FB) / h;
        if (q > 2 * one)
            return k;
        if (q < one)
        begin
            q2 = (q * q) >> FB;
            q3 = (q2 * q) >> FB;
            pos = one + ((3 * q3) >> 2);
            neg = (3 * q2) >> 1;
            f = pos > neg ? pos - neg : 0;
            neg = (9 * q2) >> 2;
            gm = 3 * q > neg ? 3 * q - neg : 0;
        end
        else
        begin
            t = 2 * one - q;
            t2 = (t * t) >> FB;
            t3 = (t2 * t) >> FB;
            f = t3 >> 2;
            gm = (3 * t2) >> 2;
        end
        h3 = 256'(h) * h * h;
        h4 = h3 * h;
        num = (256'(f) * ip) << (2 * FB);
        w = floor_div(num, h3);
        if (w > 34'h0_7FFF_FFFF)
            w = 34'h0_7FFF_FFFF;
        if (w == 0)
            return k;
        k.nb = 1'b1;
        k.w = w[WT_W-1:0];
        for (int c = 0; c < 3; c++)
        begin
            u = (64'(a[c]) << FB) / 64'(d);
            num = (256'(u) * gm * ip) << (2 * FB);
            mag = floor_div(num, h4);
            if (c == 0) k.gx = signed_grad(r[c], mag);
            if (c == 1) k.gy = signed_grad(r[c], mag);
            if (c == 2) k.gz = signed_grad(r[c], mag);
        end
        return k;
    endfunction

    task automatic send_pair(pair_t p);
        @(negedge clk);
        pair_valid <= 1'b1;
        {pos_i_x, pos_i_y, pos_i_z, pos_j_x, pos_j_y, pos_j_z} <=
            {p.pix, p.piy, p.piz, p.pjx, p.pjy, p.pjz};
        smooth_len_i <= p.hi;
        smooth_len_j <= p.hj;
        @(posedge clk);
        while (!pair_ready)
            @(posedge clk);
        expected_kernels.push_back(predict_kernel(p));
    endtask

    task automatic idle_sender(int n);
        @(negedge clk);
        pair_valid <= 1'b0;
        repeat (n - 1)
            @(negedge clk);
    endtask

    function automatic logic [SLEN_W-1:0] rand_len();
        case ($urandom_range(0, 3))
            0: return SLEN_W'($urandom_range(1, 32'h7FFF_FFFF));
            1: return SLEN_W'($urandom_range(1, 32'h0000_FFFF));
            default: return SLEN_W'($urandom_range(32'h0000_4000, 32'h0008_0000));
        endcase
    endfunction

    function automatic logic [POS_W-1:0] offset(logic [POS_W-1:0] base, int span);
        return base + POS_W'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic pair_t rand_pair();
        pair_t p;
        int span;
        p.hi = rand_len();
        p.hj = ($urandom_range(0, 1)) ? p.hi : rand_len();
        p.pix = $urandom();
        p.piy = $urandom();
        p.piz = $urandom();
        if ($urandom_range(0, 9) < 8)
        begin
            span = (int'(p.hi) + int'(p.hj)) / 2;
            if (span > 32'h3FFF_FFFF || span < 1)
                span = 32'h0002_0000;
            span = span / ($urandom_range(1, 3));
            if (span < 1)
                span = 1;
            p.pjx = offset(p.pix, span);
            p.pjy = offset(p.piy, span);
            p.pjz = offset(p.piz, span);
        end
        else
        begin
            p.pjx = $urandom();
            p.pjy = $urandom();
            p.pjz = $urandom();
        end
        return p;
    endfunction

    task automatic test_extremes();
        pair_t p;
        logic [POS_W-1:0] ext[4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
        foreach (ext[m])
        begin
            p.pix = ext[m]; p.piy = ext[3 - m]; p.piz = ext[m];
            p.pjx = ext[3 - m]; p.pjy = ext[m]; p.pjz = ext[(m + 1) % 4];
            p.hi = SLEN_W'(32'h7FFF_FFFF); p.hj = SLEN_W'(32'h7FFF_FFFF);
            send_pair(p);
        end
        p = '0;
        p.hi = 1; p.hj = 1;
        send_pair(p);
        p.pix = 32'h0001_0000;
        p.hi = SLEN_W'(32'h0001_0000); p.hj = SLEN_W'(32'h0001_0000);
        send_pair(p);
        p.pix = 32'h0002_0000;
        send_pair(p);
        p.pix = 32'h0002_0001;
        send_pair(p);
        p.pix = 32'h0000_8000; p.piy = 32'hFFFF_8000; p.piz = 32'h0000_4000;
        send_pair(p);
        p.pix = 32'h0; p.piy = 32'h0; p.piz = 32'h0;
        p.pjx = 32'h0001_8000;
        send_pair(p);
        p.pix = 32'h0000_0001; p.pjx = 32'h0;
        p.hi = 1; p.hj = 2;
        send_pair(p);
        p.pix = 32'h0000_0001;
        p.hi = SLEN_W'(32'h7FFF_FFFF); p.hj = SLEN_W'(32'h7FFF_FFFF);
        send_pair(p);
        p.pix = 32'h7FFF_FFFF; p.pjx = 32'h8000_0000;
        p.hi = SLEN_W'(32'h7FFF_FFFF); p.hj = 1;
        send_pair(p);
        p.pix = 32'h0000_0010; p.piy = 32'hFFFF_FFF0; p.piz = 32'h0000_0003;
        p.pjx = 32'h0; p.pjy = 32'h0; p.pjz = 32'h0;
        p.hi = 20; p.hj = 21;
        send_pair(p);
    endtask

    task automatic test_random_stream(int n);
        int sent;
        int burst;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < n; k++)
            begin
                send_pair(rand_pair());
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                idle_sender($urandom_range(1, 12));
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        test_random_stream(250);
        hold_off = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (!hold_off)
            quiet_sink <= ($urandom_range(0, 3) == 0);
    end

    initial
    begin
        int span;
        res_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                res_ready <= 1'b0;
                for (span = 0; span < 600; span++)
                    @(negedge clk);
                hold_off = 1'b0;
            end
            res_ready <= quiet_sink ? 1'b1 : ($urandom_range(0, 4) != 0);
        end
    end

    always @(posedge clk)
    begin
        kernel_t exp_k, got_k;
        if (rst_n && res_valid && res_ready)
        begin
            got_k = '{is_neighbor, weight, grad_x, grad_y, grad_z};
            if (expected_kernels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", got_k);
            end
            else
            begin
                exp_k = expected_kernels.pop_front();
                if (got_k !== exp_k)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: nb %b/%b w %h/%h gx %h/%h gy %h/%h gz %h/%h",
                                 exp_k.nb, got_k.nb, exp_k.w, got_k.w, exp_k.gx,
                                 got_k.gx, exp_k.gy, got_k.gy, exp_k.gz, got_k.gz);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pair_valid && pair_ready) || (res_valid && res_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int drain;
        mismatches = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        quiet_sink = 1'b0;
        rst_n = 1'b0;
        pair_valid = 1'b0;
        {pos_i_x, pos_i_y, pos_i_z, pos_j_x, pos_j_y, pos_j_z} = '0;
        smooth_len_i = '0;
        smooth_len_j = '0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_extremes();
        test_random_stream(600);
        test_backpressure();
        test_random_stream(580);
        idle_sender(1);
        while (expected_kernels.size() != 0)
            @(posedge clk);
        for (drain = 0; drain < 2 * LATENCY; drain++)
            @(posedge clk);
        if (mismatches == 0 && expected_kernels.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/spk_pkg.sv
hdl/spk_div.sv
hdl/sph_pair_kernel_gradient_unit.sv
hdl/spk_check.sv
bench/tb.sv
